>>> hdl/bgpfsm_pkg.sv
// bgpfsm_pkg: event, state and message codes and shared types for the bgp peer session fsm
package bgpfsm_pkg;

	// field widths
	localparam int CmdW    = 4;
	localparam int StateW  = 3;
	localparam int SendW   = 2;
	localparam int CodeW   = 8;
	localparam int AsW     = 16;
	localparam int HoldW   = 16;
	localparam int RidW    = 32;
	localparam int MarkW   = 64;
	localparam int ByteW   = 8;
	localparam int CfgIdxW = 2;
	localparam int CfgDatW = 32;

	// event codes
	localparam logic [CmdW-1:0] CMD_START     = 4'd0;
	localparam logic [CmdW-1:0] CMD_STOP      = 4'd1;
	localparam logic [CmdW-1:0] CMD_TCP_UP    = 4'd2;
	localparam logic [CmdW-1:0] CMD_TCP_CLOSE = 4'd3;
	localparam logic [CmdW-1:0] CMD_TCP_FATAL = 4'd4;
	localparam logic [CmdW-1:0] CMD_TCP_FAIL  = 4'd5;
	localparam logic [CmdW-1:0] CMD_RETRY_TMO = 4'd6;
	localparam logic [CmdW-1:0] CMD_HOLD_TMO  = 4'd7;
	localparam logic [CmdW-1:0] CMD_KA_TMO    = 4'd8;
	localparam logic [CmdW-1:0] CMD_OPEN_RX   = 4'd9;
	localparam logic [CmdW-1:0] CMD_KA_RX     = 4'd10;
	localparam logic [CmdW-1:0] CMD_UPDATE_RX = 4'd11;
	localparam logic [CmdW-1:0] CMD_NOTIF_RX  = 4'd12;

	// session states
	localparam logic [StateW-1:0] ST_IDLE        = 3'd0;
	localparam logic [StateW-1:0] ST_CONNECT     = 3'd1;
	localparam logic [StateW-1:0] ST_ACTIVE      = 3'd2;
	localparam logic [StateW-1:0] ST_OPENSENT    = 3'd3;
	localparam logic [StateW-1:0] ST_OPENCONFIRM = 3'd4;
	localparam logic [StateW-1:0] ST_ESTAB       = 3'd5;

	// message kinds to send
	localparam logic [SendW-1:0] SEND_NONE   = 2'd0;
	localparam logic [SendW-1:0] SEND_OPEN   = 2'd1;
	localparam logic [SendW-1:0] SEND_KEEP   = 2'd2;
	localparam logic [SendW-1:0] SEND_NOTIFY = 2'd3;

	// notification error codes
	localparam logic [CodeW-1:0] NOTIF_NONE     = 8'd0;
	localparam logic [CodeW-1:0] NOTIF_OPEN_ERR = 8'd2;
	localparam logic [CodeW-1:0] NOTIF_HOLD_EXP = 8'd4;

	// open message checks
	localparam logic [ByteW-1:0] MSG_TYPE_OPEN = 8'd1;
	localparam logic [ByteW-1:0] BGP_VERSION   = 8'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_LOCAL_AS  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_HOLD_TIME = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_ROUTER_ID = 2'd2;

	// registered event: command plus the precomputed open check
	typedef struct packed {
		logic [CmdW-1:0] cmd;
		logic            open_ok;
	} evt_t;

	// outcome of one transition
	typedef struct packed {
		logic [StateW-1:0] state;
		logic [SendW-1:0]  send;
		logic [CodeW-1:0]  code;
		logic              conn;
	} step_t;

endpackage

>>> hdl/bgpfsm_if.sv
// bgpfsm_if: valid/ready channels for session events and session results

interface bgpfsm_evt_if;
	import bgpfsm_pkg::*;
	logic             valid;
	logic             ready;
	logic [CmdW-1:0]  cmd;
	logic [MarkW-1:0] marker_upper;
	logic [MarkW-1:0] marker_lower;
	logic [ByteW-1:0] rx_msg_type;
	logic [ByteW-1:0] rx_version;
	logic [HoldW-1:0] rx_hold_time;

	modport source (output valid, cmd, marker_upper, marker_lower, rx_msg_type, rx_version,
		rx_hold_time, input ready);
	modport sink (input valid, cmd, marker_upper, marker_lower, rx_msg_type, rx_version,
		rx_hold_time, output ready);
endinterface

interface bgpfsm_res_if;
	import bgpfsm_pkg::*;
	logic              valid;
	logic              ready;
	logic [StateW-1:0] new_state;
	logic [SendW-1:0]  send_kind;
	logic [CodeW-1:0]  notify_code;
	logic [AsW-1:0]    open_as_number;
	logic [HoldW-1:0]  open_hold_time;
	logic [RidW-1:0]   open_router_id;
	logic              connect_request;

	modport source (output valid, new_state, send_kind, notify_code, open_as_number,
		open_hold_time, open_router_id, connect_request, input ready);
	modport sink (input valid, new_state, send_kind, notify_code, open_as_number,
		open_hold_time, open_router_id, connect_request, output ready);
endinterface

>>> hdl/bgpfsm_event_reg.sv
// bgpfsm_event_reg: input register stage, keeps the command and the open message check
module bgpfsm_event_reg import bgpfsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bgpfsm_evt_if.sink evt,
	input  logic       adv,
	output logic       vld_s1,
	output evt_t       evt_s1
);

	logic open_ok;

	// valid open: all-ones marker, type open, version 4, nonzero hold time
	assign open_ok = (&evt.marker_upper) && (&evt.marker_lower) &&
		(evt.rx_msg_type == MSG_TYPE_OPEN) && (evt.rx_version == BGP_VERSION) &&
		(|evt.rx_hold_time);

	// stage is free when empty or when its request moves on this cycle
	assign evt.ready = !vld_s1 || adv;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (evt.ready) begin
			vld_s1 <= evt.valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			evt_s1.cmd     <= evt.cmd;
			evt_s1.open_ok <= open_ok;
		end
	end

endmodule

>>> hdl/bgpfsm_next.sv
// bgpfsm_next: session transition logic, next state and message for one event
module bgpfsm_next import bgpfsm_pkg::*; (
	input  logic [StateW-1:0] state,
	input  evt_t              evt,
	output step_t             step
);

	logic in_sync;
	logic in_conn;

	assign in_sync = (state == ST_OPENCONFIRM) || (state == ST_ESTAB);
	assign in_conn = (state == ST_CONNECT) || (state == ST_ACTIVE);

	// transition table
	always_comb begin
		step.state = state;
		step.send  = SEND_NONE;
		step.code  = NOTIF_NONE;
		step.conn  = 1'b0;
		unique case (evt.cmd)
			CMD_START: begin
				if (state == ST_IDLE) step.state = ST_CONNECT;
				step.conn = 1'b1;
			end
			CMD_STOP, CMD_TCP_FATAL, CMD_NOTIF_RX: begin
				step.state = ST_IDLE;
			end
			CMD_TCP_UP: begin
				if (in_conn) begin
					step.send  = SEND_OPEN;
					step.state = ST_OPENSENT;
				end else begin
					step.state = ST_IDLE;
				end
			end
			CMD_TCP_CLOSE: begin
				step.state = (state == ST_OPENSENT) ? ST_ACTIVE : ST_IDLE;
			end
			CMD_TCP_FAIL: begin
				step.state = in_conn ? ST_ACTIVE : ST_IDLE;
			end
			CMD_RETRY_TMO: begin
				step.state = (state == ST_ACTIVE) ? ST_CONNECT : ST_IDLE;
			end
			CMD_HOLD_TMO: begin
				if (in_sync) begin
					step.send = SEND_NOTIFY;
					step.code = NOTIF_HOLD_EXP;
				end
				step.state = ST_IDLE;
			end
			CMD_KA_TMO: begin
				if (in_sync) step.send = SEND_KEEP;
				else step.state = ST_IDLE;
			end
			CMD_OPEN_RX: begin
				if (state == ST_OPENSENT && evt.open_ok) begin
					step.send  = SEND_KEEP;
					step.state = ST_OPENCONFIRM;
				end else if (state == ST_OPENSENT) begin
					step.send  = SEND_NOTIFY;
					step.code  = NOTIF_OPEN_ERR;
					step.state = ST_IDLE;
				end else begin
					step.state = ST_IDLE;
				end
			end
			CMD_KA_RX: begin
				step.state = in_sync ? ST_ESTAB : ST_IDLE;
			end
			CMD_UPDATE_RX: begin
				step.state = (state == ST_ESTAB) ? ST_ESTAB : ST_IDLE;
			end
			// unknown event codes keep everything as is
			default: begin
				step.state = state;
			end
		endcase
	end

endmodule

>>> hdl/bgp_peer_session_fsm_top.sv
// bgp_peer_session_fsm_top: bgp peer session state machine with config registers
//
//  channel | dir | handshake   | payload
//  evt     | in  | valid/ready | cmd, marker_upper/lower, rx_msg_type, rx_version, rx_hold_time
//  res     | out | valid/ready | new_state, send_kind, notify_code, open_*, connect_request
//  cfg     | in  | cfg_we      | cfg_idx, cfg_wdata
//
// Each request passes an input register and a result register, one request per cycle
// sustained while res.ready holds, set by the single session state register update.
// Reset clears the session state to idle and all config registers to zero.
// A stalled result keeps its register; the input register still takes one more request.
module bgp_peer_session_fsm_top import bgpfsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	bgpfsm_evt_if.sink         evt,
	bgpfsm_res_if.source       res,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [CfgDatW-1:0] cfg_wdata
);

	logic              vld_s1;
	evt_t              evt_s1;
	logic              adv;
	step_t             nxt;
	logic [StateW-1:0] state_q;
	logic [AsW-1:0]    local_as_q;
	logic [HoldW-1:0]  hold_time_q;
	logic [RidW-1:0]   router_id_q;
	logic              res_vld_q;
	logic              is_open;

	// input register
	bgpfsm_event_reg u_event_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.adv    (adv),
		.vld_s1 (vld_s1),
		.evt_s1 (evt_s1)
	);

	// transition logic
	bgpfsm_next u_next (
		.state (state_q),
		.evt   (evt_s1),
		.step  (nxt)
	);

	// request moves into the result register when that register is free
	assign adv     = vld_s1 && (!res_vld_q || res.ready);
	assign is_open = (nxt.send == SEND_OPEN);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_as_q  <= '0;
			hold_time_q <= '0;
			router_id_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_LOCAL_AS:  local_as_q  <= cfg_wdata[AsW-1:0];
				CFG_HOLD_TIME: hold_time_q <= cfg_wdata[HoldW-1:0];
				CFG_ROUTER_ID: router_id_q <= cfg_wdata[RidW-1:0];
				default:       local_as_q  <= local_as_q;
			endcase
		end
	end

	// session state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_vld_q <= 1'b0;
		end else begin
			if (adv) state_q <= nxt.state;
			if (adv) res_vld_q <= 1'b1;
			else if (res.ready) res_vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res.new_state       <= nxt.state;
			res.send_kind       <= nxt.send;
			res.notify_code     <= nxt.code;
			res.connect_request <= nxt.conn;
			res.open_as_number  <= is_open ? local_as_q  : '0;
			res.open_hold_time  <= is_open ? hold_time_q : '0;
			res.open_router_id  <= is_open ? router_id_q : '0;
		end
	end

	assign res.valid = res_vld_q;

	// a sent open always leaves the session in opensent
	a_open_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && nxt.send == SEND_OPEN |=> res.new_state == ST_OPENSENT)
		else $error("open sent outside opensent");

	// a notification always drops the session to idle with a nonzero code
	a_notify_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.send_kind == SEND_NOTIFY |->
		res.new_state == ST_IDLE && res.notify_code != NOTIF_NONE)
		else $error("notification without idle or code");

	// session state only moves when a request advances
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("session state changed without a request");

	// the result register shows the state it just stored
	a_state_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res.valid && res.new_state == state_q)
		else $error("result state differs from session state");

endmodule

>>> tb/sv/bgp_session_checker.sv
// bgp_session_checker: session state predictor and result comparator for the bgp peer session fsm
`timescale 1ns / 100ps

module bgp_session_checker import bgpfsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	bgpfsm_evt_if              evt,
	bgpfsm_res_if              res,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_idx,
	input  logic [CfgDatW-1:0] cfg_wdata,
	output int                 fail_count,
	output int                 pending
);

	// one predicted session result
	typedef struct packed {
		logic [StateW-1:0] state;
		logic [SendW-1:0]  send;
		logic [CodeW-1:0]  code;
		logic [AsW-1:0]    as_num;
		logic [HoldW-1:0]  hold;
		logic [RidW-1:0]   rid;
		logic              conn;
	} session_result_t;

	// shadow of the session state and the config registers
	logic [StateW-1:0] sess_state;
	logic [AsW-1:0]    local_as;
	logic [HoldW-1:0]  local_hold;
	logic [RidW-1:0]   local_rid;

	session_result_t   expected_results[$];
	session_result_t   predicted;
	session_result_t   observed;
	int                errs = 0;

	// received open passes marker, type, version and hold time checks
	function automatic logic open_well_formed(input logic [MarkW-1:0] mk_up,
		input logic [MarkW-1:0] mk_lo, input logic [ByteW-1:0] msg_type,
		input logic [ByteW-1:0] version, input logic [HoldW-1:0] hold);
		return (&mk_up) && (&mk_lo) && (msg_type == MSG_TYPE_OPEN) &&
			(version == BGP_VERSION) && (hold != '0);
	endfunction

	// next state and outgoing message for one session event
	function automatic session_result_t next_session(input logic [StateW-1:0] cur,
		input logic [CmdW-1:0] cmd, input logic open_ok);
		session_result_t r;
		logic synced;
		logic linking;
		synced  = (cur == ST_OPENCONFIRM) || (cur == ST_ESTAB);
		linking = (cur == ST_CONNECT) || (cur == ST_ACTIVE);
		r       = '0;
		r.state = cur;
		r.send  = SEND_NONE;
		r.code  = NOTIF_NONE;
		case (cmd)
			CMD_START: begin
				if (cur == ST_IDLE)
					r.state = ST_CONNECT;
				r.conn = 1'b1;
			end
			CMD_STOP, CMD_TCP_FATAL, CMD_NOTIF_RX: r.state = ST_IDLE;
			CMD_TCP_UP: begin
				if (linking) begin
					r.send  = SEND_OPEN;
					r.state = ST_OPENSENT;
				end else
					r.state = ST_IDLE;
			end
			CMD_TCP_CLOSE: r.state = (cur == ST_OPENSENT) ? ST_ACTIVE : ST_IDLE;
			CMD_TCP_FAIL:  r.state = linking ? ST_ACTIVE : ST_IDLE;
			CMD_RETRY_TMO: r.state = (cur == ST_ACTIVE) ? ST_CONNECT : ST_IDLE;
			CMD_HOLD_TMO: begin
				if (synced) begin
					r.send = SEND_NOTIFY;
					r.code = NOTIF_HOLD_EXP;
				end
				r.state = ST_IDLE;
			end
			CMD_KA_TMO: begin
				if (synced)
					r.send = SEND_KEEP;
				else
					r.state = ST_IDLE;
			end
			CMD_OPEN_RX: begin
				if (cur != ST_OPENSENT)
					r.state = ST_IDLE;
				else if (open_ok) begin
					r.send  = SEND_KEEP;
					r.state = ST_OPENCONFIRM;
				end else begin
					r.send  = SEND_NOTIFY;
					r.code  = NOTIF_OPEN_ERR;
					r.state = ST_IDLE;
				end
			end
			CMD_KA_RX:     r.state = synced ? ST_ESTAB : ST_IDLE;
			CMD_UPDATE_RX: r.state = (cur == ST_ESTAB) ? ST_ESTAB : ST_IDLE;
			// unassigned event codes leave everything as is
			default: ;
		endcase
		if (r.send == SEND_OPEN) begin
			r.as_num = local_as;
			r.hold   = local_hold;
			r.rid    = local_rid;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// track config, predict each request, compare each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sess_state = ST_IDLE;
			local_as   = '0;
			local_hold = '0;
			local_rid  = '0;
			expected_results.delete();
			pending    <= 0;
			fail_count <= errs;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_LOCAL_AS:  local_as   = cfg_wdata[AsW-1:0];
					CFG_HOLD_TIME: local_hold = cfg_wdata[HoldW-1:0];
					CFG_ROUTER_ID: local_rid  = cfg_wdata[RidW-1:0];
					default: ;
				endcase
			end
			if (evt.valid && evt.ready) begin
				predicted = next_session(sess_state, evt.cmd,
					open_well_formed(evt.marker_upper, evt.marker_lower, evt.rx_msg_type,
						evt.rx_version, evt.rx_hold_time));
				sess_state = predicted.state;
				expected_results.push_back(predicted);
			end
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					errs++;
					$display("%0t: result with no request pending, state 0x%0h send 0x%0h",
						$time, res.new_state, res.send_kind);
				end else begin
					observed = expected_results.pop_front();
					check_field("new_state", 32'(observed.state), 32'(res.new_state));
					check_field("send_kind", 32'(observed.send), 32'(res.send_kind));
					check_field("notify_code", 32'(observed.code), 32'(res.notify_code));
					check_field("open_as_number", 32'(observed.as_num),
						32'(res.open_as_number));
					check_field("open_hold_time", 32'(observed.hold),
						32'(res.open_hold_time));
					check_field("open_router_id", observed.rid, res.open_router_id);
					check_field("connect_request", 32'(observed.conn),
						32'(res.connect_request));
				end
			end
			pending    <= expected_results.size();
			fail_count <= errs;
		end
	end

endmodule

>>> tb/sv/tb_bgp_peer_session_fsm_top.sv
// tb_bgp_peer_session_fsm_top: directed and random session event stimulus with the final verdict
`timescale 1ns / 100ps

module tb_bgp_peer_session_fsm_top;
	import bgpfsm_pkg::*;

	// event codes the block does not assign
	localparam logic [CmdW-1:0] CMD_UNUSED_LO = 4'd13;
	localparam logic [CmdW-1:0] CMD_UNUSED_HI = 4'd15;

	// register index with no register behind it
	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

	localparam int PHASE_ITEMS     = 300;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int DRAIN_CYCLES    = 10;

	typedef enum int {
		OPEN_GOOD,
		OPEN_BAD_UPPER,
		OPEN_BAD_LOWER,
		OPEN_BAD_TYPE,
		OPEN_BAD_VERSION,
		OPEN_ZERO_HOLD
	} open_flaw_e;

	typedef struct {
		logic [CmdW-1:0]  cmd;
		logic [MarkW-1:0] mk_up;
		logic [MarkW-1:0] mk_lo;
		logic [ByteW-1:0] msg_type;
		logic [ByteW-1:0] version;
		logic [HoldW-1:0] hold;
	} session_event_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_idx = '0;
	logic [CfgDatW-1:0] cfg_wdata = '0;
	int                 fail_count;
	int                 pending;
	int                 events_sent = 0;
	bit                 sender_steady = 1'b0;
	bit                 hold_off_req = 1'b0;

	bgpfsm_evt_if evt_ch();
	bgpfsm_res_if res_ch();

	bgp_peer_session_fsm_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	bgp_session_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt_ch),
		.res        (res_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic session_event_t random_event(input logic [CmdW-1:0] cmd);
		session_event_t e;
		e.cmd      = cmd;
		e.mk_up    = {$urandom, $urandom};
		e.mk_lo    = {$urandom, $urandom};
		e.msg_type = 8'($urandom);
		e.version  = 8'($urandom);
		e.hold     = 16'($urandom);
		return e;
	endfunction

	// received open, well formed unless a flaw is asked for
	function automatic session_event_t open_event(input open_flaw_e flaw);
		session_event_t e;
		int r;
		e          = random_event(CMD_OPEN_RX);
		e.mk_up    = '1;
		e.mk_lo    = '1;
		e.msg_type = MSG_TYPE_OPEN;
		e.version  = BGP_VERSION;
		r          = $urandom_range(0, 3);
		e.hold     = (r == 0) ? 16'd1 : (r == 1) ? 16'hffff : 16'($urandom_range(1, 65535));
		case (flaw)
			OPEN_BAD_UPPER: begin
				if ($urandom_range(0, 1))
					e.mk_up[$urandom_range(0, MarkW-1)] = 1'b0;
				else
					e.mk_up = {$urandom, $urandom};
			end
			OPEN_BAD_LOWER: begin
				if ($urandom_range(0, 1))
					e.mk_lo[$urandom_range(0, MarkW-1)] = 1'b0;
				else
					e.mk_lo = {$urandom, $urandom};
			end
			OPEN_BAD_TYPE: begin
				do e.msg_type = 8'($urandom); while (e.msg_type == MSG_TYPE_OPEN);
			end
			OPEN_BAD_VERSION: begin
				do e.version = 8'($urandom); while (e.version == BGP_VERSION);
			end
			OPEN_ZERO_HOLD: e.hold = '0;
			default: ;
		endcase
		return e;
	endfunction

	// offer one request, hold it until taken, then maybe idle
	task automatic put_event(input session_event_t e);
		int gap;
		@(negedge clk);
		evt_ch.valid        <= 1'b1;
		evt_ch.cmd          <= e.cmd;
		evt_ch.marker_upper <= e.mk_up;
		evt_ch.marker_lower <= e.mk_lo;
		evt_ch.rx_msg_type  <= e.msg_type;
		evt_ch.rx_version   <= e.version;
		evt_ch.rx_hold_time <= e.hold;
		do @(posedge clk); while (!evt_ch.ready);
		events_sent++;
		gap = sender_steady ? 0 : idle_cycles();
		if (gap > 0) begin
			@(negedge clk);
			evt_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic put_cmd(input logic [CmdW-1:0] cmd);
		put_event(random_event(cmd));
	endtask

	// stop offering and wait until every result is back
	task automatic drain();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// upper data bits are written too, the narrow registers drop them
	task automatic load_config(input logic [CfgDatW-1:0] as_num, input logic [CfgDatW-1:0] hold,
		input logic [CfgDatW-1:0] rid);
		write_reg(CFG_LOCAL_AS, as_num);
		write_reg(CFG_HOLD_TIME, hold);
		write_reg(CFG_ROUTER_ID, rid);
	endtask

	// every event, both open checks, unassigned codes
	task automatic run_directed();
		session_event_t e;
		put_cmd(CMD_START);
		put_cmd(CMD_START);
		put_cmd(CMD_TCP_UP);
		e = open_event(OPEN_GOOD);
		e.hold = 16'hffff;
		put_event(e);
		put_cmd(CMD_KA_TMO);
		put_cmd(CMD_KA_RX);
		put_cmd(CMD_UPDATE_RX);
		put_cmd(CMD_KA_TMO);
		put_cmd(CMD_HOLD_TMO);
		put_cmd(CMD_START);
		put_cmd(CMD_TCP_FAIL);
		put_cmd(CMD_RETRY_TMO);
		put_cmd(CMD_TCP_FAIL);
		put_cmd(CMD_TCP_UP);
		put_cmd(CMD_TCP_CLOSE);
		put_cmd(CMD_TCP_UP);
		put_event(open_event(OPEN_ZERO_HOLD));
		put_event(open_event(OPEN_GOOD));
		put_cmd(CMD_UNUSED_LO);
		put_cmd(CMD_UNUSED_HI);
		put_cmd(CMD_START);
		put_cmd(CMD_TCP_UP);
		put_event(open_event(OPEN_BAD_VERSION));
		put_cmd(CMD_NOTIF_RX);
		put_cmd(CMD_STOP);
		put_cmd(CMD_TCP_FATAL);
	endtask

	// one connection attempt carried toward established, then torn down somehow
	task automatic session_script();
		int n;
		put_cmd(CMD_START);
		if ($urandom_range(0, 9) < 3) begin
			put_cmd(CMD_TCP_FAIL);
			if ($urandom_range(0, 1))
				put_cmd(CMD_RETRY_TMO);
		end
		put_cmd(CMD_TCP_UP);
		if ($urandom_range(0, 99) < 15) begin
			put_cmd(CMD_TCP_CLOSE);
			put_cmd(CMD_TCP_UP);
		end
		if ($urandom_range(0, 9) < 7)
			put_event(open_event(OPEN_GOOD));
		else
			put_event(open_event(open_flaw_e'($urandom_range(OPEN_BAD_UPPER, OPEN_ZERO_HOLD))));
		if ($urandom_range(0, 9) < 8)
			put_cmd(CMD_KA_RX);
		n = $urandom_range(0, 6);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0:       put_cmd(CMD_KA_TMO);
				1:       put_cmd(CMD_UPDATE_RX);
				default: put_cmd(CMD_KA_RX);
			endcase
		end
		case ($urandom_range(0, 10))
			0:  put_cmd(CMD_STOP);
			1:  put_cmd(CMD_TCP_FATAL);
			2:  put_cmd(CMD_NOTIF_RX);
			3:  put_cmd(CMD_HOLD_TMO);
			4:  put_cmd(CMD_TCP_CLOSE);
			5:  put_cmd(CMD_TCP_FAIL);
			6:  put_cmd(CMD_RETRY_TMO);
			7:  put_event(open_event(open_flaw_e'($urandom_range(OPEN_GOOD, OPEN_ZERO_HOLD))));
			8:  put_cmd(CMD_START);
			9:  put_cmd(4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)));
			default: ;
		endcase
	endtask

	// any code with any fields
	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 5);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0)
				put_event(open_event(open_flaw_e'($urandom_range(OPEN_GOOD, OPEN_ZERO_HOLD))));
			else
				put_cmd(4'($urandom_range(CMD_START, CMD_UNUSED_HI)));
		end
	endtask

	task automatic run_random(input int count);
		int target;
		target = events_sent + count;
		while (events_sent < target) begin
			sender_steady = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 3) != 0)
				session_script();
			else
				noise_burst();
		end
		sender_steady = 1'b0;
	endtask

	// result side: random ready, one long hold-off on request
	initial begin
		int on_len;
		int off_len;
		bit hold_off_done;
		hold_off_done = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_off_req && !hold_off_done) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
				hold_off_done = 1'b1;
			end
			on_len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
			@(negedge clk);
			res_ch.ready <= 1'b1;
			repeat (on_len - 1) @(negedge clk);
			off_len = idle_cycles();
			if (off_len > 0) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
				repeat (off_len - 1) @(negedge clk);
			end
		end
	end

	// main sequence
	initial begin
		evt_ch.valid        = 1'b0;
		evt_ch.cmd          = '0;
		evt_ch.marker_upper = '0;
		evt_ch.marker_lower = '0;
		evt_ch.rx_msg_type  = '0;
		evt_ch.rx_version   = '0;
		evt_ch.rx_hold_time = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// reset config is all zeros
		run_directed();
		drain();

		load_config('1, '1, '1);
		hold_off_req = 1'b1;
		run_random(PHASE_ITEMS);
		drain();

		load_config($urandom, $urandom, $urandom);
		write_reg(CFG_UNUSED, $urandom);
		run_random(PHASE_ITEMS);
		drain();

		load_config('0, '0, '0);
		run_random(PHASE_ITEMS);
		drain();

		load_config($urandom, $urandom, $urandom);
		run_random(PHASE_ITEMS);
		drain();

		load_config(32'd1, 32'd1, 32'd1);
		run_random(PHASE_ITEMS);
		drain();

		load_config($urandom, $urandom, $urandom);
		run_random(PHASE_ITEMS);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
